@@ src/srrip_pkg.sv @@
package srrip_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_OUT,
    ST_CLEAR
  } srrip_state_e;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic clear_en;
    logic rd_en;
    logic exec;
    logic out_load;
  } srrip_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic clear_done;
    logic is_victim;
  } srrip_sts_t;

  localparam logic [1:0] RrpvMax = 2'd3;
  localparam logic [1:0] RrpvInit = 2'd2;
  localparam logic [9:0] PselMax = 10'd1023;
  localparam logic [9:0] PselMid = 10'd512;
  localparam logic [15:0] LfsrTaps = 16'hB400;
  localparam logic [15:0] LfsrSeed = 16'h0001;
  localparam logic [4:0] SigMask = 5'h1F;
  localparam logic [1:0] OutcomeInit = 2'd1;
  localparam logic [1:0] ThreshInit = 2'd2;
  localparam logic KindVictim = 1'b0;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LfsrTaps;
    end
    return r;
  endfunction

endpackage

@@ src/srrip_ram.sv @@
module srrip_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ src/srrip_ctrl.sv @@
module srrip_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  srrip_pkg::srrip_sts_t   sts_i,
  output srrip_pkg::srrip_cmd_t   cmd_o
);
  import srrip_pkg::*;

  srrip_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.is_victim) state_d = ST_OUT;
        else state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (!out_valid_i || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_OUT: cmd_o.out_load = !out_valid_i || out_ready_i;
      default: cmd_o = '0;
    endcase
  end
endmodule

@@ src/srrip_dp.sv @@
module srrip_dp #(
  parameter int NumSets = 2048,
  parameter int NumWays = 16,
  parameter int LeaderSets = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srrip_pkg::srrip_cmd_t cmd_i,
  output srrip_pkg::srrip_sts_t sts_o,
  input  logic [1:0]            thresh_i,
  input  logic                  kind_i,
  input  logic [10:0]           set_index_i,
  input  logic [3:0]            way_i,
  input  logic                  hit_i,
  input  logic [63:0]           address_i,
  input  logic [63:0]           pc_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [3:0]            victim_way_o
);
  import srrip_pkg::*;

  localparam int SetW = $clog2(NumSets);
  localparam int WayW = $clog2(NumWays);
  localparam int RowW = 2 * NumWays;
  localparam int SigRowW = 5 * NumWays;
  localparam int PerSetW = 64 + 64 + 2;

  // Captured item.
  logic            kind_q;
  logic [SetW-1:0] set_q;
  logic [WayW-1:0] way_q;
  logic            hit_q;
  logic [63:0]     addr_q;
  logic [4:0]      sig_q;

  logic [SetW:0]   clr_q;
  logic [9:0]      psel_q, psel_d;
  logic [15:0]     lfsr_q, lfsr_d;
  logic [1:0]      outc_q [32];
  logic            out_valid_q;
  logic [3:0]      victim_q;
  logic [3:0]      pick_q;

  logic [SetW-1:0] set_in;
  logic [4:0]      set_low;
  logic [SetW-1:0] raddr, waddr;
  logic            we;

  // Each memory row holds a whole set; rows are written whole.
  logic [RowW-1:0]    rrpv_rd, rrpv_wr;
  logic [SigRowW-1:0] sig_rd, sig_wr;
  logic [PerSetW-1:0] ps_rd, ps_wr;

  assign set_in  = SetW'(set_index_i);
  assign set_low = 5'(set_index_i) & SigMask;
  assign raddr   = cmd_i.capture ? set_in : set_q;
  assign waddr   = cmd_i.clear_en ? clr_q[SetW-1:0] : set_q;
  assign we      = cmd_i.clear_en || cmd_i.exec;

  srrip_ram #(.Width(RowW), .Depth(NumSets)) u_rrpv (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(rrpv_wr), .raddr_i(raddr),
    .rdata_o(rrpv_rd));
  srrip_ram #(.Width(SigRowW), .Depth(NumSets)) u_sig (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(sig_wr), .raddr_i(raddr),
    .rdata_o(sig_rd));
  srrip_ram #(.Width(PerSetW), .Depth(NumSets)) u_pset (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(ps_wr), .raddr_i(raddr),
    .rdata_o(ps_rd));

  assign sts_o.clear_done = clr_q[SetW];
  assign sts_o.is_victim  = (kind_q == KindVictim);

  // Execution logic.
  logic [1:0]  mx, sc, sc_new, oc_new_old;
  logic [RowW-1:0] aged;
  logic [3:0]  pick;
  logic [63:0] last, stride, pstride;
  logic        leader, bleader, streaming, hot, use_brrip;
  logic [4:0]  old_sig;
  logic [1:0]  ins;
  logic [15:0] l1, l2;

  always_comb begin
    mx = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (rrpv_rd[2*w +: 2] > mx) mx = rrpv_rd[2*w +: 2];
    end
    pick = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      aged[2*w +: 2] = rrpv_rd[2*w +: 2] + (RrpvMax - mx);
      if (aged[2*w +: 2] == RrpvMax) pick = 4'(w);
    end
  end

  assign last    = ps_rd[129:66];
  assign pstride = ps_rd[65:2];
  assign sc      = ps_rd[1:0];
  assign stride  = (last == 64'd0) ? 64'd0 : addr_q - last;
  assign leader  = 32'(set_q) < 32'(2 * LeaderSets);
  assign bleader = leader && (32'(set_q) >= 32'(LeaderSets));
  assign old_sig = sig_rd[5*way_q +: 5];

  always_comb begin
    if (last != 64'd0 && stride != 64'd0 && stride == pstride) begin
      sc_new = (sc < 2'd3) ? sc + 2'd1 : sc;
    end else begin
      sc_new = (sc > 2'd0) ? sc - 2'd1 : sc;
    end
    psel_d = psel_q;
    if (leader && hit_q) begin
      if (bleader) begin
        if (psel_q < PselMax) psel_d = psel_q + 10'd1;
      end else if (psel_q > 10'd0) begin
        psel_d = psel_q - 10'd1;
      end
    end
    streaming = sc_new >= thresh_i;
    // Hotness is judged before the evicted block's counter is trained down.
    oc_new_old = (outc_q[old_sig] > 2'd0) ? outc_q[old_sig] - 2'd1 : 2'd0;
    hot = outc_q[sig_q] >= 2'd2;
    use_brrip = leader ? bleader : (psel_d >= PselMid);
    l1 = lfsr_step(lfsr_q);
    l2 = lfsr_step(l1);
    lfsr_d = lfsr_q;
    if (streaming && !hot) begin
      ins = RrpvMax;
    end else if (use_brrip) begin
      if ((l1[4:0]) == 5'd0) begin
        ins = 2'd0;
        lfsr_d = l1;
      end else begin
        ins = 2'd2 + {1'b0, l2[0]};
        lfsr_d = l2;
      end
    end else begin
      ins = hot ? 2'd0 : RrpvInit;
    end
  end

  always_comb begin
    if (cmd_i.clear_en) begin
      rrpv_wr = {NumWays{RrpvInit}};
      sig_wr  = '0;
      ps_wr   = '0;
    end else if (kind_q == KindVictim) begin
      rrpv_wr = aged;
      sig_wr  = sig_rd;
      ps_wr   = ps_rd;
    end else begin
      rrpv_wr = rrpv_rd;
      sig_wr  = sig_rd;
      rrpv_wr[2*way_q +: 2] = hit_q ? 2'd0 : ins;
      if (!hit_q) sig_wr[5*way_q +: 5] = sig_q;
      ps_wr = {addr_q, stride, sc_new};
    end
  end

  // The picked way waits in pick_q until the output register is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      set_q  <= set_in;
      way_q  <= WayW'(way_i);
      hit_q  <= hit_i;
      addr_q <= address_i;
      sig_q  <= (5'(pc_i >> 2) ^ set_low) & SigMask;
    end
    if (cmd_i.exec) pick_q <= pick;
    if (cmd_i.out_load) victim_q <= pick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      psel_q      <= PselMid;
      lfsr_q      <= LfsrSeed;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 32; i++) outc_q[i] <= OutcomeInit;
    end else begin
      if (cmd_i.clear_en) clr_q <= clr_q + 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      if (cmd_i.exec && kind_q != KindVictim) begin
        psel_q <= psel_d;
        if (!hit_q) lfsr_q <= lfsr_d;
        if (hit_q) begin
          if (outc_q[old_sig] < 2'd3) outc_q[old_sig] <= outc_q[old_sig] + 2'd1;
        end else begin
          outc_q[old_sig] <= oc_new_old;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;
endmodule

@@ src/ship_rrip_duel_stream_bypass_policy.sv @@
// SHiP-lite / SRRIP-BRRIP set-dueling replacement engine with streaming
// bypass. Each item is either a victim request (kind 0), which ages the set and
// returns one victim_way result, or an update (kind 1), which trains the stride,
// signature and selector state and inserts or promotes a block; updates give no
// result. An update passes through accept, memory read and read-modify-write;
// a victim request then hands its way to the output register in ST_OUT, and
// it stays in that state while an earlier result still waits for the receiver.
// The per-set row memories have a registered read before the read-modify-write.
// After reset the block sweeps the per-set memories, one set per cycle, before
// it accepts its first item; configuration writes are taken during that sweep.
module ship_rrip_duel_stream_bypass_policy #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int LEADER_SETS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_i,
  input  logic        hit_i,
  input  logic [63:0] address_i,
  input  logic [63:0] pc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  victim_way_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srrip_pkg::*;

  srrip_cmd_t cmd;
  srrip_sts_t sts;
  logic [1:0] thresh_q;

  // Only one register, at byte address 0; other addresses are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshInit;
    end else if (psel && penable && pwrite && !paddr) begin
      thresh_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr ? 32'd0 : {30'd0, thresh_q};

  srrip_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_valid_i(out_valid_o), .out_ready_i, .sts_i(sts), .cmd_o(cmd));

  srrip_dp #(.NumSets(NUM_SETS), .NumWays(NUM_WAYS), .LeaderSets(LEADER_SETS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .thresh_i(thresh_q),
    .kind_i, .set_index_i, .way_i, .hit_i, .address_i, .pc_i,
    .out_ready_i, .out_valid_o, .victim_way_o);
endmodule

@@ src/srrip_chk.sv @@
module srrip_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] victim_way_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(victim_way_o))
    else $error("result dropped while stalled");
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted two items back to back");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !out_valid_o || $past(out_valid_o, 2))
    else $error("result too early");
endmodule

bind ship_rrip_duel_stream_bypass_policy srrip_chk u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .victim_way_o);
